// ===== rtl/core/dxq_pkg.sv =====
// ----------------------------------------------------------------------------
// dxq_pkg
// Shared types and constants for the divisor-keyed xor trie query block.
// ----------------------------------------------------------------------------
package dxq_pkg;

  localparam int FIELD_W          = 17;
  localparam int VALUE_BITS_DEF   = 17;
  localparam int NODE_POOL_DEF    = 4194304;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] divisor;
    logic [FIELD_W-1:0] sum_limit;
  } dxq_req_t;

  typedef struct packed {
    logic               found;
    logic [FIELD_W-1:0] best_value;
    logic               pool_overflow;
  } dxq_rsp_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_INS_TEST, ST_INS_DIVW, ST_NEXT_I,
    ST_ADD_BEGIN, ST_ADD_RD, ST_ADD_LINK, ST_ADD_CHILD, ST_ADD_LVL, ST_ADD_END,
    ST_ADD_NEXT,
    ST_Q_CHK, ST_Q_DIVW, ST_Q_CHK2, ST_Q_ROOT,
    ST_W_RD, ST_W_C0, ST_W_C1, ST_W_STEP, ST_W_LVL,
    ST_RES_NF, ST_RES_FOUND
  } dxq_state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_LOAD,
    CMD_INS_DIV, CMD_NEXT_I,
    CMD_ADD_BEGIN, CMD_RD_NODE, CMD_INS_LINK, CMD_WR_CHILD, CMD_LVL_DEC,
    CMD_ADD_NEXT,
    CMD_Q_DIV, CMD_Q_ROOT,
    CMD_W_C0, CMD_W_C1, CMD_W_STEP,
    CMD_RES_NF, CMD_RES_FOUND
  } dxq_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_query;
    logic isq_gt_x;
    logic div_done;
    logic rem_zero;
    logic second;
    logic phase;
    logic add_ok;
    logic link_zero;
    logic lvl_zero;
    logic k_zero;
    logic q_ok;
    logic root_ok;
  } dxq_status_t;

endpackage

// ===== rtl/core/dxq_div.sv =====
// ----------------------------------------------------------------------------
// dxq_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dxq_div import dxq_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [VALUE_BITS-1:0] remainder
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic              running;
  logic [CNT_W-1:0]  cnt;
  logic [VALUE_BITS:0]   rem;
  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] dv;
  logic [VALUE_BITS:0]   rem_sh;

  assign rem_sh = {rem[VALUE_BITS-1:0], quo[VALUE_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(VALUE_BITS);
        rem     <= '0;
        quo     <= dividend;
        dv      <= divisor;
      end else if (running) begin
        if (rem_sh >= {1'b0, dv}) begin
          rem <= rem_sh - {1'b0, dv};
          quo <= {quo[VALUE_BITS-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[VALUE_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem[VALUE_BITS-1:0];

endmodule

// ===== rtl/core/dxq_dp.sv =====
// ----------------------------------------------------------------------------
// dxq_dp
// Datapath: node memory, trial-division registers, trie walk and result.
// ----------------------------------------------------------------------------
module dxq_dp import dxq_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int NODE_POOL  = NODE_POOL_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  dxq_cmd_t    cmd,
  input  dxq_req_t    req,
  output dxq_status_t status,
  output logic        done,
  output dxq_rsp_t    rsp
);

  localparam int VB    = VALUE_BITS;
  localparam int NW    = $clog2(NODE_POOL);
  localparam int MW    = VB + 1;
  localparam int RW    = 2 * NW + MW;
  localparam int CW    = ((VB > NW) ? VB : NW) + 2;
  localparam int LW    = $clog2(VB);
  localparam int ROOTS = 1 << VB;
  localparam int NROOT = (ROOTS < NODE_POOL) ? ROOTS : NODE_POOL;
  localparam logic [MW-1:0] EMPTY = MW'(ROOTS);

  logic [RW-1:0] mem [NODE_POOL];
  logic [RW-1:0] rdata;
  logic [NW-1:0] raddr;
  logic [NW-1:0] waddr;
  logic [RW-1:0] wdata;
  logic          we;

  logic            is_q;
  logic [VB-1:0]   x, k, s, i, root, lim, v;
  logic [2*VB-1:0] isq;
  logic            phase;
  logic [NW-1:0]   node, c0, c1;
  logic [LW-1:0]   lvl;
  logic [CW-1:0]   nfree;
  logic            ovf;
  logic            u0;
  logic [VB:0]     clr;

  logic            div_start, div_done;
  logic [VB-1:0]   div_n, div_d, quo, rem;

  logic [NW-1:0] r_zero, r_one, link, n_new, step_node;
  logic [MW-1:0] r_min, new_min;
  logic          bit_u, u1, go_one;

  dxq_div #(.VALUE_BITS(VB)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  assign div_start = (cmd == CMD_INS_DIV) || (cmd == CMD_Q_DIV);
  assign div_n     = x;
  assign div_d     = (cmd == CMD_Q_DIV) ? k : i;

  assign r_zero  = rdata[RW-1 -: NW];
  assign r_one   = rdata[MW +: NW];
  assign r_min   = rdata[MW-1:0];
  assign bit_u   = x[lvl];
  assign link    = bit_u ? r_one : r_zero;
  assign new_min = (r_min > {1'b0, x}) ? {1'b0, x} : r_min;
  assign n_new   = NW'(nfree + CW'(1));

  // walk choice: prefer the child whose bit differs from x
  assign u1     = (c1 != '0) && (r_min <= {1'b0, lim});
  assign go_one = !u0 || (u1 && !x[lvl]);
  assign step_node = go_one ? c1 : c0;

  always_comb begin
    raddr = node;
    case (cmd)
      CMD_Q_ROOT: raddr = NW'(k);
      CMD_W_C0:   raddr = r_zero;
      CMD_W_C1:   raddr = c1;
      default:    raddr = node;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = rdata;
    case (cmd)
      CMD_CLEAR: begin
        we    = 1'b1;
        waddr = NW'(clr);
        wdata = {{(2*NW){1'b0}}, EMPTY};
      end
      CMD_INS_LINK: begin
        we = 1'b1;
        if (link == '0) begin
          if (bit_u) wdata = {r_zero, n_new, new_min};
          else       wdata = {n_new, r_one, new_min};
        end else begin
          wdata = {r_zero, r_one, new_min};
        end
      end
      CMD_WR_CHILD: begin
        we    = 1'b1;
        wdata = {{(2*NW){1'b0}}, 1'b0, x};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr   <= '0;
      nfree <= CW'(ROOTS);
      ovf   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cmd)
        CMD_CLEAR: clr <= clr + 1'b1;
        CMD_LOAD: begin
          is_q  <= req.action;
          x     <= VB'(req.value);
          k     <= VB'(req.divisor);
          s     <= VB'(req.sum_limit);
          i     <= VB'(1);
          isq   <= (2*VB)'(1);
          phase <= 1'b0;
        end
        CMD_NEXT_I: begin
          i     <= i + 1'b1;
          isq   <= isq + {{(VB-1){1'b0}}, i, 1'b1};
          phase <= 1'b0;
        end
        CMD_ADD_BEGIN: begin
          if (status.add_ok) begin
            node <= NW'(root);
            lvl  <= LW'(VB - 1);
          end else begin
            ovf <= 1'b1;
          end
        end
        CMD_INS_LINK: begin
          if (link == '0) begin
            nfree <= CW'(n_new);
            node  <= n_new;
          end else begin
            node <= link;
          end
        end
        CMD_LVL_DEC: lvl <= lvl - 1'b1;
        CMD_ADD_NEXT: phase <= 1'b1;
        CMD_Q_ROOT: begin
          node <= NW'(k);
          lim  <= s - x;
          lvl  <= LW'(VB - 1);
          v    <= '0;
        end
        CMD_W_C0: begin
          c0 <= r_zero;
          c1 <= r_one;
        end
        CMD_W_C1: u0 <= (c0 != '0) && (r_min <= {1'b0, lim});
        CMD_W_STEP: begin
          if (go_one) v[lvl] <= 1'b1;
          node <= (CW'(step_node) >= CW'(NODE_POOL)) ? '0 : step_node;
        end
        CMD_RES_NF: begin
          done <= 1'b1;
          rsp  <= '{found: 1'b0, best_value: '0, pool_overflow: ovf};
        end
        CMD_RES_FOUND: begin
          done <= 1'b1;
          rsp  <= '{found: 1'b1, best_value: FIELD_W'(v), pool_overflow: ovf};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    root = phase ? quo : i;
  end

  assign status.clear_done = (clr == (VB+1)'(NROOT - 1));
  assign status.is_query   = is_q;
  assign status.isq_gt_x   = isq > (2*VB)'(x);
  assign status.div_done   = div_done;
  assign status.rem_zero   = (rem == '0);
  assign status.second     = (isq != (2*VB)'(x));
  assign status.phase      = phase;
  assign status.add_ok     = (CW'(root) < CW'(NODE_POOL)) &&
                             (nfree + CW'(VB) < CW'(NODE_POOL));
  assign status.link_zero  = (link == '0);
  assign status.lvl_zero   = (lvl == '0);
  assign status.k_zero     = (k == '0);
  assign status.q_ok       = (rem == '0) && (s >= x) && (CW'(k) < CW'(NODE_POOL));
  assign status.root_ok    = (r_min <= {1'b0, lim});

endmodule

// ===== rtl/core/dxq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dxq_ctrl
// Sequencer for root clearing, inserts and queries.
// ----------------------------------------------------------------------------
module dxq_ctrl import dxq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  dxq_status_t status,
  output logic        busy,
  output dxq_cmd_t    cmd
);

  dxq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (status.clear_done) state_next = ST_IDLE;
      ST_IDLE:      if (start) state_next = ST_Q_CHK;
      ST_INS_TEST:  state_next = status.isq_gt_x ? ST_IDLE : ST_INS_DIVW;
      ST_INS_DIVW:  if (status.div_done)
                      state_next = status.rem_zero ? ST_ADD_BEGIN : ST_NEXT_I;
      ST_NEXT_I:    state_next = ST_INS_TEST;
      ST_ADD_BEGIN: state_next = status.add_ok ? ST_ADD_RD : ST_ADD_END;
      ST_ADD_RD:    state_next = ST_ADD_LINK;
      ST_ADD_LINK:  state_next = status.link_zero ? ST_ADD_CHILD : ST_ADD_LVL;
      ST_ADD_CHILD: state_next = ST_ADD_LVL;
      ST_ADD_LVL:   state_next = status.lvl_zero ? ST_ADD_END : ST_ADD_RD;
      ST_ADD_END:   state_next = (!status.phase && status.second) ? ST_ADD_NEXT
                                                                  : ST_NEXT_I;
      ST_ADD_NEXT:  state_next = ST_ADD_BEGIN;
      ST_Q_CHK: begin
        if (!status.is_query)   state_next = ST_INS_TEST;
        else if (status.k_zero) state_next = ST_RES_NF;
        else                    state_next = ST_Q_DIVW;
      end
      ST_Q_DIVW:    if (status.div_done) state_next = ST_Q_CHK2;
      ST_Q_CHK2:    state_next = status.q_ok ? ST_Q_ROOT : ST_RES_NF;
      ST_Q_ROOT:    state_next = status.root_ok ? ST_W_RD : ST_RES_NF;
      ST_W_RD:      state_next = ST_W_C0;
      ST_W_C0:      state_next = ST_W_C1;
      ST_W_C1:      state_next = ST_W_STEP;
      ST_W_STEP:    state_next = ST_W_LVL;
      ST_W_LVL:     state_next = status.lvl_zero ? ST_RES_FOUND : ST_W_RD;
      ST_RES_NF:    state_next = ST_IDLE;
      ST_RES_FOUND: state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Q_ROOT holds no command: the root read is issued in Q_CHK2
  always_comb begin
    cmd = CMD_NONE;
    case (state)
      ST_CLEAR:     cmd = CMD_CLEAR;
      ST_IDLE:      if (start) cmd = CMD_LOAD;
      ST_INS_TEST:  if (!status.isq_gt_x) cmd = CMD_INS_DIV;
      ST_NEXT_I:    cmd = CMD_NEXT_I;
      ST_ADD_BEGIN: cmd = CMD_ADD_BEGIN;
      ST_ADD_RD:    cmd = CMD_RD_NODE;
      ST_ADD_LINK:  cmd = CMD_INS_LINK;
      ST_ADD_CHILD: cmd = CMD_WR_CHILD;
      ST_ADD_LVL:   cmd = CMD_LVL_DEC;
      ST_ADD_NEXT:  cmd = CMD_ADD_NEXT;
      ST_Q_CHK:     if (status.is_query && !status.k_zero) cmd = CMD_Q_DIV;
      ST_Q_CHK2:    if (status.q_ok) cmd = CMD_Q_ROOT;
      ST_W_RD:      cmd = CMD_RD_NODE;
      ST_W_C0:      cmd = CMD_W_C0;
      ST_W_C1:      cmd = CMD_W_C1;
      ST_W_STEP:    cmd = CMD_W_STEP;
      ST_W_LVL:     cmd = CMD_LVL_DEC;
      ST_RES_NF:    cmd = CMD_RES_NF;
      ST_RES_FOUND: cmd = CMD_RES_FOUND;
      default:      cmd = CMD_NONE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== rtl/core/divisor_xor_trie_max_query.sv =====
// ----------------------------------------------------------------------------
// divisor_xor_trie_max_query
// Divisor-keyed binary tries with a bounded maximum-xor lookup.
// ----------------------------------------------------------------------------
// After reset the block clears the min(2^VALUE_BITS, NODE_POOL) trie roots
// with busy high. A transaction is taken when start is high and busy low;
// one is handled at a time. A query first runs the divisibility test on the
// bit-serial divider, then walks each trie level through the node read,
// child reads, step and level states, set by the one read a cycle of the
// node memory. An insert runs a trial division for each divisor up to
// sqrt(value) and descends every divisor trie it adds to. A query result
// appears on rsp for one cycle with done high; the receiver cannot stall it.
module divisor_xor_trie_max_query import dxq_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int NODE_POOL  = NODE_POOL_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dxq_req_t req,
  output logic     busy,
  output logic     done,
  output dxq_rsp_t rsp
);

  dxq_cmd_t    cmd;
  dxq_status_t status;

  dxq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .status(status), .busy(busy), .cmd(cmd)
  );

  dxq_dp #(.VALUE_BITS(VALUE_BITS), .NODE_POOL(NODE_POOL)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(req), .status(status),
    .done(done), .rsp(rsp)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a transaction");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("transaction not taken");

  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.found) |-> (rsp.best_value == '0))
    else $error("not-found result carries a value");

endmodule

// ===== tb/sv/divisor_xor_trie_max_query_tb.sv =====
// ----------------------------------------------------------------------------
// divisor_xor_trie_max_query_tb
// Self-checking bench: a software trie predicts each query answer, and the
// scoreboard compares every done-strobed response with the oldest one.
// ----------------------------------------------------------------------------
module divisor_xor_trie_max_query_tb;
  import dxq_pkg::*;

  localparam int VBITS = VALUE_BITS_DEF;
  localparam int POOL  = NODE_POOL_DEF;
  localparam int ROOTS = 1 << VBITS;
  localparam int VMASK = ROOTS - 1;

  class trie_scoreboard;
    int        zero_link[int];
    int        one_link[int];
    int        min_below[int];
    int        free_top;
    bit        pool_short;
    dxq_rsp_t  pending[$];
    int        errors;

    function new();
      free_top   = ROOTS;
      pool_short = 1'b0;
      errors     = 0;
    endfunction

    function int node_min(int n);
      if (min_below.exists(n)) return min_below[n];
      return (n < ROOTS) ? ROOTS : 0;
    endfunction

    function int link_of(int n, bit b);
      if (b) return one_link.exists(n) ? one_link[n] : 0;
      return zero_link.exists(n) ? zero_link[n] : 0;
    endfunction

    function void add_value(int root, int u);
      int n;
      int c;
      bit b;
      if (root >= POOL || longint'(free_top) + VBITS >= longint'(POOL)) begin
        pool_short = 1'b1;
        return;
      end
      n = root;
      for (int lvl = VBITS - 1; lvl >= 0; lvl--) begin
        b = bit'((u >> lvl) & 1);
        if (node_min(n) > u) min_below[n] = u;
        c = link_of(n, b);
        if (c == 0) begin
          free_top++;
          c = free_top;
          if (b) one_link[n] = c;
          else zero_link[n] = c;
          min_below[c] = u;
        end
        n = c;
      end
      min_below[n] = u;
    endfunction

    function bit fits(int c, int lim);
      return c != 0 && node_min(c) <= lim;
    endfunction

    function int best_match(int root, int x, int lim);
      int n, v, c0, c1;
      n = root;
      v = 0;
      for (int lvl = VBITS - 1; lvl >= 0; lvl--) begin
        c0 = link_of(n, 1'b0);
        c1 = link_of(n, 1'b1);
        if (!fits(c0, lim)) begin
          n = c1; v |= 1 << lvl;
        end else if (!fits(c1, lim)) begin
          n = c0;
        end else if ((x >> lvl) & 1) begin
          n = c0;
        end else begin
          n = c1; v |= 1 << lvl;
        end
        if (n >= POOL) n = 0;
      end
      return v & VMASK;
    endfunction

    // accepted transaction: update the tries or queue the expected answer
    function void note(dxq_req_t r);
      int x, k, s;
      dxq_rsp_t e;
      x = int'(r.value) & VMASK;
      k = int'(r.divisor) & VMASK;
      s = int'(r.sum_limit) & VMASK;
      if (r.action == ACT_INSERT) begin
        for (int i = 1; i * i <= x; i++) begin
          if (x % i == 0) begin
            add_value(i, x);
            if (i * i != x) add_value(x / i, x);
          end
        end
        return;
      end
      e = '0;
      if (k != 0 && x % k == 0 && s >= x && k < POOL) begin
        if (node_min(k) <= s - x) begin
          e.found      = 1'b1;
          e.best_value = FIELD_W'(best_match(k, x, s - x));
        end
      end
      e.pool_overflow = pool_short;
      pending.push_back(e);
    endfunction

    function void check(dxq_rsp_t a);
      dxq_rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected response %p", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.found !== e.found) begin
        $error("found: expected %0d actual %0d", e.found, a.found);
        errors++;
      end
      if (a.best_value !== e.best_value) begin
        $error("best_value: expected %0d actual %0d", e.best_value, a.best_value);
        errors++;
      end
      if (a.pool_overflow !== e.pool_overflow) begin
        $error("pool_overflow: expected %0d actual %0d", e.pool_overflow,
               a.pool_overflow);
        errors++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  dxq_req_t req = '0;
  logic     busy;
  logic     done;
  dxq_rsp_t rsp;

  trie_scoreboard sb = new();
  int stored[$];

  divisor_xor_trie_max_query uut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(rsp);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(input logic act, input int v, input int k, input int s);
    req.action    = act;
    req.value     = v[FIELD_W-1:0];
    req.divisor   = k[FIELD_W-1:0];
    req.sum_limit = s[FIELD_W-1:0];
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note(req);
    if (act == ACT_INSERT) stored.push_back(v & VMASK);
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // query built around a stored value so the trie walk has work to do
  task automatic shaped_query();
    int v, d, k, m, x, s, room;
    v = stored[$urandom_range(0, stored.size() - 1)];
    if (v == 0) v = 1;
    d = $urandom_range(1, (v < 64) ? v : 64);
    while (v % d != 0) d--;
    k = $urandom_range(0, 1) ? d : v / d;
    m = (ROOTS - 1 - v) / k;
    m = $urandom_range(0, 3) == 0 ? $urandom_range(0, m) : $urandom_range(0, m < 4 ? m : 4);
    x = k * m;
    room = ROOTS - 1 - x;
    case ($urandom_range(0, 3))
      0: s = x + $urandom_range(0, room);
      1: s = x + v - $urandom_range(0, 1);
      default: s = x + v + $urandom_range(0, room - v < 64 ? room - v : 64);
    endcase
    send(ACT_QUERY, x, k, s);
  endtask

  initial begin
    int burst;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    send(ACT_QUERY, 0, 1, 131071);        // empty trie
    send(ACT_INSERT, 0, 131071, 131071);  // zero stores nothing
    send(ACT_QUERY, 0, 1, 131071);
    send(ACT_INSERT, 1, 0, 0);
    send(ACT_INSERT, 131071, 0, 0);
    send(ACT_INSERT, 131070, 0, 0);
    send(ACT_INSERT, 65536, 0, 0);
    send(ACT_INSERT, 720, 0, 0);
    send(ACT_QUERY, 0, 1, 131071);
    send(ACT_QUERY, 131071, 131071, 131071);
    send(ACT_QUERY, 0, 131071, 131071);
    send(ACT_QUERY, 4, 0, 131071);        // zero divisor
    send(ACT_QUERY, 7, 2, 131071);        // divisor does not divide
    send(ACT_QUERY, 100, 2, 99);          // bound below x
    send(ACT_QUERY, 0, 5, 4);             // trie minimum too large
    send(ACT_QUERY, 0, 7, 131071);        // empty divisor trie
    send(ACT_QUERY, 2, 2, 722);
    send(ACT_QUERY, 0, 16, 65536);
    send(ACT_QUERY, 0, 16, 65535);
    send(ACT_QUERY, 0, 65535, 131071);
    send(ACT_QUERY, 10, 5, 131071);
    idle_cycles(3);

    // random part in bursts
    for (int n = 0; n < 150; ) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst; b++, n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send(ACT_INSERT, $urandom_range(0, VMASK),
                           $urandom_range(0, VMASK), $urandom_range(0, VMASK));
          4: send(ACT_INSERT, $urandom_range(1, 2048), 0, 0);
          5: send(ACT_QUERY, $urandom_range(0, VMASK), $urandom_range(0, VMASK),
                  $urandom_range(0, VMASK));
          default: shaped_query();
        endcase
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 20));
    end
    start = 1'b0;

    while (sb.pending.size() != 0 || busy) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("divisor_xor_trie_max_query: match");
    else
      $display("divisor_xor_trie_max_query: mismatch");
    $finish;
  end

  initial begin
    #40000000;
    $display("divisor_xor_trie_max_query: mismatch");
    $finish;
  end
endmodule
